// ----- rtl/bucket_rms_loudness_gate_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Immediate-cycle and next-cycle implication checks, compiled out in synthesis.
// ----------------------------------------------------------------------------
`ifndef BUCKET_RMS_LOUDNESS_GATE_UNIT_ASSERT_SVH
`define BUCKET_RMS_LOUDNESS_GATE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define BRLG_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BRLG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BRLG_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define BRLG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/brlg_pkg.sv -----
// ----------------------------------------------------------------------------
// brlg_pkg
// Shared types and constants of the bucket RMS loudness gate.
// ----------------------------------------------------------------------------
package brlg_pkg;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LOUD_THRESHOLD     = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SAMPLES_PER_BUCKET = 8'd1;

    localparam logic [15:0] LOUD_THRESHOLD_RESET     = 16'd4260;
    localparam logic [15:0] SAMPLES_PER_BUCKET_RESET = 16'd22000;

    localparam int QUEUE_DEPTH   = 2;
    localparam int M_TDATA_WIDTH = 80;

    typedef struct packed {
        logic full;
        logic one_left;
    } queue_status_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIV,
        BACK_SQRT,
        BACK_FINISH
    } back_state_t;

endpackage

// ----- rtl/brlg_front.sv -----
// ----------------------------------------------------------------------------
// brlg_front
// Accepts samples, squares them, counts bucket position and accumulates.
// ----------------------------------------------------------------------------
module brlg_front #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int SUM_WIDTH    = 46
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic [15:0]                    samples_per_bucket,
    input  brlg_pkg::queue_status_t        q_status,
    output logic                           push_valid,
    output logic [SUM_WIDTH+15:0]          push_data
);

    localparam int SQ_WIDTH = 2 * SAMPLE_WIDTH;

    logic [SAMPLE_WIDTH-1:0] raw;
    logic [SAMPLE_WIDTH-1:0] mag;
    logic [SQ_WIDTH-1:0]     square;
    logic [15:0]             size;
    logic [15:0]             pos_inc;
    logic                    close;
    logic                    accept;
    logic [SUM_WIDTH-1:0]    sum_total;

    logic [15:0]          pos_reg,     pos_next;
    logic                 valid1_reg,  valid1_next;
    logic                 close1_reg,  close1_next;
    logic [15:0]          size1_reg,   size1_next;
    logic [SQ_WIDTH-1:0]  square1_reg, square1_next;
    logic [SUM_WIDTH-1:0] sum_reg,     sum_next;

    assign raw    = sample;
    assign mag    = raw[SAMPLE_WIDTH-1] ? (~raw + SAMPLE_WIDTH'(1)) : raw;
    assign square = SQ_WIDTH'(mag) * SQ_WIDTH'(mag);
    assign size   = (samples_per_bucket == 16'd0) ? 16'd1 : samples_per_bucket;
    assign pos_inc = pos_reg + 16'd1;
    assign close  = (pos_inc >= size);

    assign push_valid = valid1_reg && close1_reg;
    assign s_tready   = !q_status.full && !(q_status.one_left && push_valid);
    assign accept     = s_tvalid && s_tready;
    assign sum_total  = sum_reg + SUM_WIDTH'(square1_reg);
    assign push_data  = {size1_reg, sum_total};

    always_comb begin
        pos_next     = pos_reg;
        valid1_next  = accept;
        close1_next  = close1_reg;
        size1_next   = size1_reg;
        square1_next = square1_reg;
        sum_next     = sum_reg;
        if (accept) begin
            pos_next     = close ? 16'd0 : pos_inc;
            close1_next  = close;
            size1_next   = size;
            square1_next = square;
        end
        if (valid1_reg) begin
            sum_next = close1_reg ? '0 : sum_total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            valid1_reg <= 1'b0;
            close1_reg <= 1'b0;
            sum_reg    <= '0;
        end else begin
            pos_reg    <= pos_next;
            valid1_reg <= valid1_next;
            close1_reg <= close1_next;
            sum_reg    <= sum_next;
        end
        size1_reg   <= size1_next;
        square1_reg <= square1_next;
    end

endmodule

// ----- rtl/brlg_queue.sv -----
// ----------------------------------------------------------------------------
// brlg_queue
// Short register queue of closed buckets between the front and back parts.
// ----------------------------------------------------------------------------
`include "bucket_rms_loudness_gate_unit_assert.svh"

module brlg_queue #(
    parameter int WIDTH = 62
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push_valid,
    input  logic [WIDTH-1:0]        push_data,
    output brlg_pkg::queue_status_t status,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output logic [WIDTH-1:0]        pop_data
);

    localparam int DEPTH   = brlg_pkg::QUEUE_DEPTH;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic pop;

    assign pop             = pop_valid && pop_ready;
    assign pop_valid       = (count_reg != '0);
    assign pop_data        = entry_reg[rd_ptr_reg];
    assign status.full     = (count_reg == COUNT_W'(DEPTH));
    assign status.one_left = (count_reg == COUNT_W'(DEPTH - 1));

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_valid && !pop) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (pop && !push_valid) begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `BRLG_ASSERT_NOW(a_no_overflow, aclk, aresetn, push_valid, !status.full)
    `BRLG_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= COUNT_W'(DEPTH))
    `BRLG_ASSERT_NEXT(a_push_counts, aclk, aresetn, push_valid && !pop, count_reg == $past(count_reg) + COUNT_W'(1))

endmodule

// ----- rtl/brlg_back.sv -----
// ----------------------------------------------------------------------------
// brlg_back
// Divides a closed bucket sum by its size, takes the square root, judges the
// level and updates the bucket counts into the output register.
// ----------------------------------------------------------------------------
`include "bucket_rms_loudness_gate_unit_assert.svh"

module brlg_back #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 32,
    parameter int SUM_WIDTH    = 46
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  logic [SUM_WIDTH+15:0]               q_data,
    input  logic [15:0]                         loud_threshold,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [brlg_pkg::M_TDATA_WIDTH-1:0]  m_tdata,
    output logic                                m_tuser
);

    localparam int ROOT_W = SUM_WIDTH / 2;
    localparam int SREM_W = ROOT_W + 2;
    localparam int STEP_W = $clog2(SUM_WIDTH + 1);
    localparam logic [ROOT_W-1:0] RMS_MAX = ROOT_W'(1) << (SAMPLE_WIDTH - 1);

    brlg_pkg::back_state_t state_reg, state_next;

    logic [SUM_WIDTH-1:0]    q_reg,    q_next;
    logic [16:0]             rem_reg,  rem_next;
    logic [15:0]             d_reg,    d_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [SREM_W-1:0]       srem_reg, srem_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0] out_rms_reg,   out_rms_next;
    logic                    out_good_reg,  out_good_next;
    logic [COUNT_WIDTH-1:0]  good_cnt_reg,  good_cnt_next;
    logic [COUNT_WIDTH-1:0]  closed_cnt_reg, closed_cnt_next;

    logic [16:0]             rem_sh;
    logic [SREM_W-1:0]       srem_sh;
    logic [SREM_W-1:0]       trial;
    logic [SAMPLE_WIDTH-1:0] rms_sat;
    logic                    good;
    logic                    load;

    assign rem_sh  = {rem_reg[15:0], q_reg[SUM_WIDTH-1]};
    assign srem_sh = {srem_reg[SREM_W-3:0], q_reg[SUM_WIDTH-1:SUM_WIDTH-2]};
    assign trial   = {root_reg, 2'b01};
    assign rms_sat = SAMPLE_WIDTH'((root_reg > RMS_MAX) ? RMS_MAX : root_reg);
    assign good    = (32'(rms_sat) > 32'(loud_threshold));
    assign load    = (state_reg == brlg_pkg::BACK_FINISH) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            brlg_pkg::BACK_IDLE: begin
                if (q_valid) state_next = brlg_pkg::BACK_DIV;
            end
            brlg_pkg::BACK_DIV: begin
                if (step_reg == STEP_W'(SUM_WIDTH - 1)) state_next = brlg_pkg::BACK_SQRT;
            end
            brlg_pkg::BACK_SQRT: begin
                if (step_reg == STEP_W'(ROOT_W - 1)) state_next = brlg_pkg::BACK_FINISH;
            end
            brlg_pkg::BACK_FINISH: begin
                if (load) state_next = brlg_pkg::BACK_IDLE;
            end
            default: state_next = brlg_pkg::BACK_IDLE;
        endcase
    end

    always_comb begin
        q_ready         = 1'b0;
        q_next          = q_reg;
        rem_next        = rem_reg;
        d_next          = d_reg;
        root_next       = root_reg;
        srem_next       = srem_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_rms_next    = out_rms_reg;
        out_good_next   = out_good_reg;
        good_cnt_next   = good_cnt_reg;
        closed_cnt_next = closed_cnt_reg;
        case (state_reg)
            brlg_pkg::BACK_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    q_next    = q_data[SUM_WIDTH-1:0];
                    d_next    = q_data[SUM_WIDTH+15:SUM_WIDTH];
                    rem_next  = '0;
                    step_next = '0;
                end
            end
            brlg_pkg::BACK_DIV: begin
                if (rem_sh >= {1'b0, d_reg}) begin
                    rem_next = rem_sh - {1'b0, d_reg};
                    q_next   = {q_reg[SUM_WIDTH-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[SUM_WIDTH-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_WIDTH - 1)) begin
                    step_next = '0;
                    root_next = '0;
                    srem_next = '0;
                end
            end
            brlg_pkg::BACK_SQRT: begin
                if (srem_sh >= trial) begin
                    srem_next = srem_sh - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    srem_next = srem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                q_next    = {q_reg[SUM_WIDTH-3:0], 2'b00};
                step_next = step_reg + STEP_W'(1);
            end
            brlg_pkg::BACK_FINISH: begin
                if (load) begin
                    out_valid_next  = 1'b1;
                    out_rms_next    = rms_sat;
                    out_good_next   = good;
                    closed_cnt_next = (&closed_cnt_reg) ? closed_cnt_reg
                                                        : closed_cnt_reg + COUNT_WIDTH'(1);
                    if (good) begin
                        good_cnt_next = (&good_cnt_reg) ? good_cnt_reg
                                                        : good_cnt_reg + COUNT_WIDTH'(1);
                    end
                end
            end
            default: begin
                q_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= brlg_pkg::BACK_IDLE;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            good_cnt_reg   <= '0;
            closed_cnt_reg <= '0;
        end else begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
            good_cnt_reg   <= good_cnt_next;
            closed_cnt_reg <= closed_cnt_next;
        end
        q_reg        <= q_next;
        rem_reg      <= rem_next;
        d_reg        <= d_next;
        root_reg     <= root_next;
        srem_reg     <= srem_next;
        out_rms_reg  <= out_rms_next;
        out_good_reg <= out_good_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_good_reg;
    assign m_tdata  = {32'(closed_cnt_reg), 32'(good_cnt_reg), 16'(out_rms_reg)};

    `BRLG_ASSERT_NEXT(a_load_shows, aclk, aresetn, load, out_valid_reg)
    `BRLG_ASSERT_NOW(a_good_le_closed, aclk, aresetn, 1'b1, good_cnt_reg <= closed_cnt_reg)
    `BRLG_ASSERT_NOW(a_rms_bound, aclk, aresetn, out_valid_reg, 32'(out_rms_reg) <= 32'(RMS_MAX))

endmodule

// ----- rtl/bucket_rms_loudness_gate_unit.sv -----
// ----------------------------------------------------------------------------
// bucket_rms_loudness_gate_unit
// Windowed RMS level detector with a loudness gate and bucket counters.
// ----------------------------------------------------------------------------
// One sample is taken per clock while the closed-bucket queue has room. Each
// closed bucket then leaves the queue, runs through the bit-serial divider and
// the square root and loads the output register; the back end works on one
// bucket at a time. The queue holds two closed buckets, so buckets longer than
// the back end's work run at one sample per clock while the output is taken,
// and shorter ones are paced by the divider and root unit.
module bucket_rms_loudness_gate_unit #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 32,
    localparam int S_TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: sample.
    input  logic [S_TDATA_WIDTH-1:0]             s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0: rms_level, good_total, bucket_total.
    output logic [brlg_pkg::M_TDATA_WIDTH-1:0]   m_tdata,
    // Fields from bit 0: is_good.
    output logic                                 m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [brlg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [brlg_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int SUM_WIDTH = 2 * SAMPLE_WIDTH + 14;
    localparam int Q_WIDTH   = SUM_WIDTH + 16;

    logic [15:0] loud_threshold_reg,     loud_threshold_next;
    logic [15:0] samples_per_bucket_reg, samples_per_bucket_next;

    brlg_pkg::queue_status_t q_status;
    logic                    push_valid;
    logic [Q_WIDTH-1:0]      push_data;
    logic                    pop_valid;
    logic                    pop_ready;
    logic [Q_WIDTH-1:0]      pop_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        loud_threshold_next     = loud_threshold_reg;
        samples_per_bucket_next = samples_per_bucket_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == brlg_pkg::CFG_LOUD_THRESHOLD) begin
                loud_threshold_next = cfg_data;
            end else if (cfg_index == brlg_pkg::CFG_SAMPLES_PER_BUCKET) begin
                samples_per_bucket_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loud_threshold_reg     <= brlg_pkg::LOUD_THRESHOLD_RESET;
            samples_per_bucket_reg <= brlg_pkg::SAMPLES_PER_BUCKET_RESET;
        end else begin
            loud_threshold_reg     <= loud_threshold_next;
            samples_per_bucket_reg <= samples_per_bucket_next;
        end
    end

    brlg_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SUM_WIDTH    (SUM_WIDTH)
    ) u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .sample             (s_tdata[SAMPLE_WIDTH-1:0]),
        .samples_per_bucket (samples_per_bucket_reg),
        .q_status           (q_status),
        .push_valid         (push_valid),
        .push_data          (push_data)
    );

    brlg_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .status     (q_status),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    brlg_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .SUM_WIDTH    (SUM_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (pop_valid),
        .q_ready        (pop_ready),
        .q_data         (pop_data),
        .loud_threshold (loud_threshold_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

endmodule

// ----- tb/bucket_rms_loudness_gate_unit_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bucket_rms_loudness_gate_unit_checker
// Watches the sample, level and register channels of the loudness gate. It
// keeps its own copy of the bucket accumulator, the registers and the bucket
// counters. It predicts the level result of every bucket that closes and
// compares each level transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bucket_rms_loudness_gate_unit_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [15:0]                          s_tdata,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [brlg_pkg::M_TDATA_WIDTH-1:0]   m_tdata,
    input  logic                                 m_tuser,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [brlg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [brlg_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                                   levels_pending,
    output int                                   mismatch_count
);

    localparam logic [23:0] RMS_CEILING = 24'd32768;
    localparam int          PRINT_LIMIT = 40;

    typedef struct packed {
        logic [15:0] rms_level;
        logic        is_good;
        logic [31:0] good_total;
        logic [31:0] bucket_total;
    } bucket_level_t;

    bucket_level_t expected_levels[$];

    logic [15:0] loud_threshold;
    logic [15:0] size_setting;
    logic [45:0] square_sum;
    logic [15:0] fill_count;
    logic [31:0] good_buckets;
    logic [31:0] closed_buckets;

    function automatic logic [23:0] floor_root(input logic [45:0] value);
        logic [23:0] root;
        logic [23:0] trial;
        root = '0;
        for (int b = 23; b >= 0; b--) begin
            trial = root | (24'd1 << b);
            if (48'(trial) * 48'(trial) <= 48'(value)) begin
                root = trial;
            end
        end
        return root;
    endfunction

    task automatic report_mismatch(input string message);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t ns: %s", $time, message);
        end
        mismatch_count++;
    endtask

    task automatic accumulate_sample(input logic [15:0] raw);
        logic [16:0]   magnitude;
        logic [15:0]   size;
        logic [23:0]   root;
        bucket_level_t level;
        magnitude  = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        square_sum = square_sum + 46'(magnitude) * 46'(magnitude);
        fill_count = fill_count + 16'd1;
        size       = (size_setting == '0) ? 16'd1 : size_setting;
        if (fill_count >= size) begin
            root            = floor_root(square_sum / 46'(size));
            level.rms_level = (root > RMS_CEILING) ? RMS_CEILING[15:0] : root[15:0];
            level.is_good   = level.rms_level > loud_threshold;
            if (level.is_good && good_buckets != '1) begin
                good_buckets = good_buckets + 32'd1;
            end
            if (closed_buckets != '1) begin
                closed_buckets = closed_buckets + 32'd1;
            end
            level.good_total   = good_buckets;
            level.bucket_total = closed_buckets;
            expected_levels.insert(expected_levels.size(), level);
            square_sum = '0;
            fill_count = '0;
        end
    endtask

    task automatic check_level(input logic [brlg_pkg::M_TDATA_WIDTH-1:0] data,
                               input logic good);
        bucket_level_t want;
        if (expected_levels.size() == 0) begin
            report_mismatch($sformatf("level transaction with none expected, rms %0d",
                                      data[15:0]));
            return;
        end
        want = expected_levels.pop_front();
        if (data[15:0] !== want.rms_level) begin
            report_mismatch($sformatf("rms_level got %0d, expected %0d",
                                      data[15:0], want.rms_level));
        end
        if (good !== want.is_good) begin
            report_mismatch($sformatf("is_good got %0b, expected %0b (rms %0d)",
                                      good, want.is_good, want.rms_level));
        end
        if (data[47:16] !== want.good_total) begin
            report_mismatch($sformatf("good_total got %0d, expected %0d",
                                      data[47:16], want.good_total));
        end
        if (data[79:48] !== want.bucket_total) begin
            report_mismatch($sformatf("bucket_total got %0d, expected %0d",
                                      data[79:48], want.bucket_total));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            loud_threshold = brlg_pkg::LOUD_THRESHOLD_RESET;
            size_setting   = brlg_pkg::SAMPLES_PER_BUCKET_RESET;
            square_sum     = '0;
            fill_count     = '0;
            good_buckets   = '0;
            closed_buckets = '0;
            expected_levels.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_level(m_tdata, m_tuser);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    brlg_pkg::CFG_LOUD_THRESHOLD:     loud_threshold = cfg_data;
                    brlg_pkg::CFG_SAMPLES_PER_BUCKET: size_setting   = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                accumulate_sample(s_tdata);
            end
        end
        levels_pending = expected_levels.size();
    end

endmodule

// ----- tb/bucket_rms_loudness_gate_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bucket_rms_loudness_gate_unit_tb
// Drives audio samples and register writes into the loudness gate. It runs
// a directed sequence over the sample extremes, zero and full-scale buckets,
// a bucket size lowered mid-bucket, the threshold edges, a long output hold,
// and then random phases under several sender and receiver idle patterns.
// A separate checker predicts and compares every level result.
// ----------------------------------------------------------------------------
module bucket_rms_loudness_gate_unit_tb;

    localparam int CLOCK_PERIOD   = 8;
    localparam int BACKEND_CYCLES = 71;
    localparam int SETTLE_CYCLES  = 2 * BACKEND_CYCLES;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SAMPLES  = 110;
    localparam int PRESSURE_BURST = 40;
    localparam int RUN_LIMIT      = 1_000_000;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_tvalid;
    logic                                 s_tready;
    // Fields from bit 0: sample.
    logic [15:0]                          s_tdata;
    logic                                 m_tvalid;
    logic                                 m_tready;
    // Fields from bit 0: rms_level, good_total, bucket_total.
    logic [brlg_pkg::M_TDATA_WIDTH-1:0]   m_tdata;
    // Fields from bit 0: is_good.
    logic                                 m_tuser;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [brlg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [brlg_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    int levels_pending;
    int mismatch_count;
    int send_idle_pct;
    int recv_stall_pct;
    int holds_asked;
    int holds_given;

    bucket_rms_loudness_gate_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bucket_rms_loudness_gate_unit_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .levels_pending (levels_pending),
        .mismatch_count (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLOCK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT * CLOCK_PERIOD);
        $display("Verification failed");
        $finish;
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_given != holds_asked) begin
                holds_given++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [15:0] pick_sample();
        logic [15:0] small_value;
        small_value = 16'($urandom_range(0, 300));
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return small_value;
            3:       return -small_value;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_sample(input logic [15:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (levels_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic set_threshold, input logic [15:0] threshold,
                             input logic [15:0] size);
        cfg_valid <= 1'b1;
        if (set_threshold) begin
            cfg_index <= brlg_pkg::CFG_LOUD_THRESHOLD;
            cfg_data  <= threshold;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_index <= brlg_pkg::CFG_SAMPLES_PER_BUCKET;
        cfg_data  <= size;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] size;
        logic [15:0] threshold;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holds_asked    = 0;
        holds_given    = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The reset bucket size is far too long to close here.
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        settle();
        configure(1'b0, '0, 16'd4);
        send_sample(16'd100);
        settle();
        configure(1'b1, 16'd0, 16'd1);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        settle();
        configure(1'b1, 16'd32768, 16'd0);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        settle();
        // Lowering the size under a nearly full-scale sum drives the level past full scale.
        configure(1'b1, 16'd32767, 16'd65535);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h8000);
        settle();
        configure(1'b0, '0, 16'd2);
        send_sample(16'h8000);
        settle();
        configure(1'b1, 16'd4260, 16'd3);
        send_sample(16'd4260);
        send_sample(-16'sd4260);
        send_sample(16'd4261);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'hFFFE);
        settle();

        // Output held off while the input keeps offering one-sample buckets.
        configure(1'b1, 16'd16000, 16'd1);
        holds_asked++;
        for (int i = 0; i < PRESSURE_BURST; i++) begin
            send_sample(pick_sample());
        end
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            case ($urandom_range(7))
                0:       size = 16'd1;
                1:       size = 16'd0;
                2:       size = 16'($urandom_range(30, 200));
                default: size = 16'($urandom_range(2, 12));
            endcase
            case ($urandom_range(3))
                0:       threshold = 16'd0;
                1:       threshold = 16'd32768;
                default: threshold = 16'($urandom_range(0, 24000));
            endcase
            configure(1'b1, threshold, size);
            for (int i = 0; i < PHASE_SAMPLES; i++) begin
                send_sample(pick_sample());
            end
            settle();
        end

        if (mismatch_count == 0 && levels_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- bucket_rms_loudness_gate_unit.f -----
+incdir+rtl
rtl/brlg_pkg.sv
rtl/brlg_front.sv
rtl/brlg_queue.sv
rtl/brlg_back.sv
rtl/bucket_rms_loudness_gate_unit.sv
tb/bucket_rms_loudness_gate_unit_checker.sv
tb/bucket_rms_loudness_gate_unit_tb.sv
